@@ sv/u8d_pkg.sv @@
// shared types and constants for the utf-8 to utf-16 decoder
// no dependencies; every other file but u8d_if uses it by scoped name

package u8d_pkg;

  // byte classes as seen by the front end
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_CONT,
    CLS_OTHER
  } byte_class_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ILLEGAL   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // one classified byte as it travels through the queue
  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
    logic        last;
  } item_t;

  localparam logic [15:0] SPACE_UNIT = 16'h0020;
  localparam logic [4:0]  LEAD2_MASK = 5'h1f;
  localparam logic [3:0]  LEAD3_MASK = 4'h0f;

endpackage

@@ sv/u8d_if.sv @@
// handshake channels for the decoder: byte input and code unit output
// depends on nothing

interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, byte_in, last_byte, input ready);
  modport sink   (input valid, byte_in, last_byte, output ready);
endinterface

interface u8d_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        end_of_text;

  modport source (output valid, code_unit, status, end_of_text, input ready);
  modport sink   (input valid, code_unit, status, end_of_text, output ready);
endinterface

@@ sv/u8d_front.sv @@
// front end: accepts input beats and classifies each byte
// depends on u8d_pkg and u8d_byte_if

module u8d_front (
  u8d_byte_if.sink        in,
  input  logic            queue_full,
  output logic            push,
  output u8d_pkg::item_t  item
);

  u8d_pkg::byte_class_t cls;

  always_comb begin
    unique casez (in.byte_in)
      8'b0???????: cls = u8d_pkg::CLS_ASCII;
      8'b10??????: cls = u8d_pkg::CLS_CONT;
      8'b110?????: cls = u8d_pkg::CLS_LEAD2;
      8'b1110????: cls = u8d_pkg::CLS_LEAD3;
      default:     cls = u8d_pkg::CLS_OTHER;
    endcase
  end

  assign in.ready  = !queue_full;
  assign push      = in.valid && !queue_full;
  assign item.cls  = cls;
  assign item.data = in.byte_in;
  assign item.last = in.last_byte;

endmodule

@@ sv/u8d_queue.sv @@
// two-entry queue of classified bytes between front and back end
// depends on u8d_pkg

module u8d_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8d_pkg::item_t  push_item,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output u8d_pkg::item_t  head
);

  u8d_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

@@ sv/u8d_back.sv @@
// back end: sequence state, code unit assembly and the output register
// depends on u8d_pkg and u8d_unit_if

module u8d_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  u8d_pkg::item_t  head,
  output logic            pop,
  u8d_unit_if.source      out
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [15:0] partial_value, partial_value_next;
  logic        halted, halted_next;

  logic        out_valid;
  logic [15:0] out_unit;
  u8d_pkg::status_t out_status;
  logic        out_end;

  logic        out_free;
  logic        emit;
  logic [15:0] emit_unit;
  u8d_pkg::status_t emit_status;
  logic        emit_end;
  logic [15:0] shifted;
  logic [1:0]  pending_dec;

  assign out_free = !out_valid || out.ready;
  assign pop      = head_valid && out_free;

  assign shifted     = {partial_value[9:0], head.data[5:0]};
  assign pending_dec = bytes_pending - 2'd1;

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    halted_next        = halted;
    emit               = 1'b0;
    emit_unit          = 16'h0000;
    emit_status        = u8d_pkg::ST_OK;
    emit_end           = 1'b0;
    if (pop) begin
      if (halted) begin
        // skip to the end of the text
        if (head.last) begin
          halted_next        = 1'b0;
          bytes_pending_next = 2'd0;
          partial_value_next = 16'h0000;
        end
      end else if (bytes_pending != 2'd0) begin
        if (head.cls != u8d_pkg::CLS_CONT) begin
          bytes_pending_next = 2'd0;
          partial_value_next = 16'h0000;
          halted_next        = !head.last;
          emit               = 1'b1;
          emit_status        = u8d_pkg::ST_ILLEGAL;
          emit_end           = 1'b1;
        end else if (pending_dec == 2'd0) begin
          bytes_pending_next = 2'd0;
          partial_value_next = 16'h0000;
          emit               = 1'b1;
          emit_unit          = shifted;
          emit_end           = head.last;
        end else if (head.last) begin
          bytes_pending_next = 2'd0;
          partial_value_next = 16'h0000;
          emit               = 1'b1;
          emit_status        = u8d_pkg::ST_TRUNCATED;
          emit_end           = 1'b1;
        end else begin
          bytes_pending_next = pending_dec;
          partial_value_next = shifted;
        end
      end else begin
        unique case (head.cls)
          u8d_pkg::CLS_ASCII: begin
            emit      = 1'b1;
            emit_unit = {8'h00, head.data};
            emit_end  = head.last;
          end
          u8d_pkg::CLS_LEAD2, u8d_pkg::CLS_LEAD3: begin
            if (head.last) begin
              bytes_pending_next = 2'd0;
              partial_value_next = 16'h0000;
              emit               = 1'b1;
              emit_status        = u8d_pkg::ST_TRUNCATED;
              emit_end           = 1'b1;
            end else if (head.cls == u8d_pkg::CLS_LEAD2) begin
              partial_value_next = {11'h000, head.data[4:0] & u8d_pkg::LEAD2_MASK};
              bytes_pending_next = 2'd1;
            end else begin
              partial_value_next = {12'h000, head.data[3:0] & u8d_pkg::LEAD3_MASK};
              bytes_pending_next = 2'd2;
            end
          end
          default: begin
            // stray continuation, four-byte lead or other invalid byte
            emit      = 1'b1;
            emit_unit = u8d_pkg::SPACE_UNIT;
            emit_end  = head.last;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_value <= 16'h0000;
      halted        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
      halted        <= halted_next;
      if (out_free) out_valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_unit   <= emit_unit;
      out_status <= emit_status;
      out_end    <= emit_end;
    end
  end

  assign out.valid       = out_valid;
  assign out.code_unit   = out_unit;
  assign out.status      = out_status;
  assign out.end_of_text = out_end;

endmodule

@@ sv/utf8_to_utf16_decoder.sv @@
// top level of the utf-8 to utf-16 decoder: front end, queue, back end
// depends on u8d_pkg, u8d_if, u8d_front, u8d_queue, u8d_back
//
//   channel  dir  beat carries
//   in       in   byte_in[7:0], last_byte
//   out      out  code_unit[15:0], status[1:0], end_of_text
//
// one byte per clock sustained while the output is not stalled; a result passes
// through a queue slot, then the output register; bytes with no result just drop out
// synchronous rst empties the queue, clears the sequence state and the output valid
// a stalled output holds the back end; in.ready falls once both queue slots
// are taken, and is still low in the cycle in which the back end first pops again

module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  u8d_byte_if.sink    in,
  u8d_unit_if.source  out
);

  logic            push;
  logic            pop;
  logic            queue_full;
  logic            head_valid;
  u8d_pkg::item_t  push_item;
  u8d_pkg::item_t  head;

  u8d_front front (
    .in         (in),
    .queue_full (queue_full),
    .push       (push),
    .item       (push_item)
  );

  u8d_queue queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  u8d_back back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out        (out)
  );

endmodule
